// ===== design/pldec_pkg.sv =====
// Package for the posting list nibble decoder.
// Holds the shared types, codes and constants; depends on nothing.
package pldec_pkg;

   localparam int unsigned ID_MAX_DIGITS_DEF = 8;
   localparam int unsigned CNT_W             = 4;
   localparam int unsigned ID_W              = 28;
   localparam int unsigned FREQ_W            = 32;
   localparam int unsigned QUEUE_DEPTH       = 2;

   localparam logic [3:0] NIB_END   = 4'd10;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_UP_A  = 8'h41;
   localparam logic [7:0] CHR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHR_LO_A  = 8'h61;
   localparam logic [7:0] CHR_LO_Z  = 8'h7A;

   // Result kinds seen on the response channel.
   localparam logic [1:0] KIND_CHAR    = 2'd0;
   localparam logic [1:0] KIND_WORDEND = 2'd1;
   localparam logic [1:0] KIND_POSTING = 2'd2;
   localparam logic [1:0] KIND_STOP    = 2'd3;

   typedef enum logic [2:0] {
      PH_WSTART,
      PH_WORD,
      PH_ID,
      PH_FREQ,
      PH_FIELD,
      PH_STOP
   } phase_type;

   // Operations handed from the front to the back through the queue.
   typedef enum logic [2:0] {
      OP_CHAR,
      OP_WEND,
      OP_STOP,
      OP_NIBS,
      OP_FIELD
   } op_type;

   // What the back does with one nibble of a posting byte.
   typedef enum logic [1:0] {
      NA_NONE,
      NA_ID,
      NA_FREQ
   } nib_act_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      nib_act_type hi_act;
      nib_act_type lo_act;
   } item_type;

endpackage

// ===== design/pldec_front.sv =====
// Front end of the decoder: accepts stream bytes and classifies them.
// Tracks the record phase and id digit count; uses pldec_pkg.
module pldec_front #(
   parameter int unsigned ID_MAX_DIGITS = pldec_pkg::ID_MAX_DIGITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   output logic               push,
   output pldec_pkg::item_type push_item
);

   typedef struct packed {
      pldec_pkg::phase_type   ph;
      logic [pldec_pkg::CNT_W-1:0] cnt;
      pldec_pkg::nib_act_type act;
   } nib_step_type;

   pldec_pkg::phase_type          phase_ff, phase_in;
   logic [pldec_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   nib_step_type                  hi_step, lo_step;
   logic                          emit;
   logic                          is_alpha;

   // One nibble of the id or frequency: only the phase and digit count matter here.
   function automatic nib_step_type nib_step(
      input pldec_pkg::phase_type ph,
      input logic [pldec_pkg::CNT_W-1:0] cnt,
      input logic [3:0] d
   );
      nib_step_type r;
      logic [pldec_pkg::CNT_W-1:0] cnt_next;
      r.ph  = ph;
      r.cnt = cnt;
      r.act = pldec_pkg::NA_NONE;
      cnt_next = cnt + pldec_pkg::CNT_W'(1);
      if (ph == pldec_pkg::PH_ID) begin
         if (d == pldec_pkg::NIB_END) begin
            r.ph = pldec_pkg::PH_FREQ;
         end else begin
            r.act = pldec_pkg::NA_ID;
            r.cnt = cnt_next;
            if (cnt_next >= pldec_pkg::CNT_W'(ID_MAX_DIGITS)) begin
               r.ph = pldec_pkg::PH_FREQ;
            end
         end
      end else if (ph == pldec_pkg::PH_FREQ) begin
         if (d == pldec_pkg::NIB_END) begin
            r.ph = pldec_pkg::PH_FIELD;
         end else begin
            r.act = pldec_pkg::NA_FREQ;
         end
      end
      return r;
   endfunction

   assign is_alpha = ((data_byte >= pldec_pkg::CHR_UP_A) && (data_byte <= pldec_pkg::CHR_UP_Z)) ||
                     ((data_byte >= pldec_pkg::CHR_LO_A) && (data_byte <= pldec_pkg::CHR_LO_Z));

   always_comb begin
      hi_step = nib_step(phase_ff, cnt_ff, data_byte[7:4]);
      // A frequency ended on the high nibble skips the low nibble.
      if (hi_step.ph == pldec_pkg::PH_FIELD) begin
         lo_step = hi_step;
         lo_step.act = pldec_pkg::NA_NONE;
      end else begin
         lo_step = nib_step(hi_step.ph, hi_step.cnt, data_byte[3:0]);
      end

      phase_in         = phase_ff;
      cnt_in           = cnt_ff;
      emit             = 1'b1;
      push_item.op     = pldec_pkg::OP_NIBS;
      push_item.data   = data_byte;
      push_item.hi_act = pldec_pkg::NA_NONE;
      push_item.lo_act = pldec_pkg::NA_NONE;

      case (phase_ff)
         pldec_pkg::PH_WSTART: begin
            if (is_alpha) begin
               push_item.op = pldec_pkg::OP_CHAR;
               phase_in     = pldec_pkg::PH_WORD;
            end else begin
               push_item.op = pldec_pkg::OP_STOP;
               phase_in     = pldec_pkg::PH_STOP;
            end
         end
         pldec_pkg::PH_WORD: begin
            // The word always holds its first letter here, so a space always ends it.
            if (data_byte == pldec_pkg::CHR_SPACE) begin
               push_item.op = pldec_pkg::OP_WEND;
               phase_in     = pldec_pkg::PH_ID;
               cnt_in       = '0;
            end else begin
               push_item.op = pldec_pkg::OP_CHAR;
            end
         end
         pldec_pkg::PH_ID, pldec_pkg::PH_FREQ: begin
            push_item.op     = pldec_pkg::OP_NIBS;
            push_item.hi_act = hi_step.act;
            push_item.lo_act = lo_step.act;
            phase_in         = lo_step.ph;
            cnt_in           = lo_step.cnt;
         end
         pldec_pkg::PH_FIELD: begin
            push_item.op = pldec_pkg::OP_FIELD;
            phase_in     = data_byte[0] ? pldec_pkg::PH_WSTART : pldec_pkg::PH_ID;
            cnt_in       = '0;
         end
         default: begin
            emit     = 1'b0;
            phase_in = pldec_pkg::PH_STOP;
         end
      endcase
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pldec_pkg::PH_WSTART;
         cnt_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== design/pldec_queue.sv =====
// Short queue between the front and back of the decoder.
// Holds classified items in order; uses pldec_pkg.
module pldec_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pldec_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output pldec_pkg::item_type head_item
);

   localparam int unsigned DEPTH = pldec_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pldec_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/pldec_back.sv =====
// Back end of the decoder: accumulates id and frequency and forms results.
// Drives the registered result channel; uses pldec_pkg.
module pldec_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  pldec_pkg::item_type        q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_char_byte,
   output logic [pldec_pkg::ID_W-1:0] rsp_doc_id,
   output logic [pldec_pkg::FREQ_W-1:0] rsp_term_freq,
   output logic [4:0]                 rsp_field_code,
   output logic                       rsp_last_posting,
   output logic                       rsp_freq_overflow
);

   localparam int unsigned ID_W   = pldec_pkg::ID_W;
   localparam int unsigned FREQ_W = pldec_pkg::FREQ_W;
   localparam int unsigned WIDE_W = FREQ_W + 4;

   logic [ID_W-1:0]   id_ff, id_in, id_mid;
   logic [FREQ_W-1:0] freq_ff, freq_in, freq_mid;
   logic              sat_ff, sat_in, sat_mid;
   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [7:0]        char_ff, char_in;
   logic [ID_W-1:0]   doc_ff, doc_in;
   logic [FREQ_W-1:0] tf_ff, tf_in;
   logic [4:0]        field_ff, field_in;
   logic              last_ff, last_in;
   logic              ovf_ff, ovf_in;
   logic              needs_out;
   logic              out_free;

   function automatic logic [ID_W-1:0] id_digit(input logic [ID_W-1:0] x, input logic [3:0] d);
      return (x << 3) + (x << 1) + ID_W'(d);
   endfunction

   // Frequency digit with saturation; bit FREQ_W of the result is the saturate flag.
   function automatic logic [FREQ_W:0] freq_digit(input logic [FREQ_W-1:0] x,
                                                  input logic [3:0] d);
      logic [WIDE_W-1:0] w;
      w = (WIDE_W'(x) << 3) + (WIDE_W'(x) << 1) + WIDE_W'(d);
      if (w[WIDE_W-1:FREQ_W] != '0) begin
         return {1'b1, {FREQ_W{1'b1}}};
      end
      return {1'b0, w[FREQ_W-1:0]};
   endfunction

   assign needs_out = (q_item.op != pldec_pkg::OP_NIBS);
   assign out_free  = !valid_ff || !rsp_stall;
   assign q_pop     = q_valid && (!needs_out || out_free);

   always_comb begin
      logic [FREQ_W:0] f1, f2;
      id_mid   = id_ff;
      freq_mid = freq_ff;
      sat_mid  = sat_ff;
      id_in    = id_ff;
      freq_in  = freq_ff;
      sat_in   = sat_ff;
      f1       = '0;
      f2       = '0;

      // High nibble first, then low nibble.
      case (q_item.hi_act)
         pldec_pkg::NA_ID:   id_mid = id_digit(id_ff, q_item.data[7:4]);
         pldec_pkg::NA_FREQ: begin
            f1       = freq_digit(freq_ff, q_item.data[7:4]);
            freq_mid = f1[FREQ_W-1:0];
            sat_mid  = sat_ff | f1[FREQ_W];
         end
         default: ;
      endcase

      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      kind_in  = kind_ff;
      char_in  = char_ff;
      doc_in   = doc_ff;
      tf_in    = tf_ff;
      field_in = field_ff;
      last_in  = last_ff;
      ovf_in   = ovf_ff;

      if (q_pop) begin
         if (needs_out) begin
            valid_in = 1'b1;
            char_in  = '0;
            doc_in   = '0;
            tf_in    = '0;
            field_in = '0;
            last_in  = 1'b0;
            ovf_in   = 1'b0;
         end
         case (q_item.op)
            pldec_pkg::OP_CHAR: begin
               kind_in = pldec_pkg::KIND_CHAR;
               char_in = q_item.data;
            end
            pldec_pkg::OP_WEND: begin
               kind_in = pldec_pkg::KIND_WORDEND;
               id_in   = '0;
               freq_in = '0;
               sat_in  = 1'b0;
            end
            pldec_pkg::OP_STOP: begin
               kind_in = pldec_pkg::KIND_STOP;
            end
            pldec_pkg::OP_FIELD: begin
               kind_in  = pldec_pkg::KIND_POSTING;
               doc_in   = id_ff;
               tf_in    = freq_ff;
               field_in = q_item.data[7:3];
               last_in  = q_item.data[0];
               ovf_in   = sat_ff;
               id_in    = '0;
               freq_in  = '0;
               sat_in   = 1'b0;
            end
            pldec_pkg::OP_NIBS: begin
               id_in   = id_mid;
               freq_in = freq_mid;
               sat_in  = sat_mid;
               case (q_item.lo_act)
                  pldec_pkg::NA_ID:   id_in = id_digit(id_mid, q_item.data[3:0]);
                  pldec_pkg::NA_FREQ: begin
                     f2      = freq_digit(freq_mid, q_item.data[3:0]);
                     freq_in = f2[FREQ_W-1:0];
                     sat_in  = sat_mid | f2[FREQ_W];
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         id_ff    <= '0;
         freq_ff  <= '0;
         sat_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         id_ff    <= id_in;
         freq_ff  <= freq_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      char_ff  <= char_in;
      doc_ff   <= doc_in;
      tf_ff    <= tf_in;
      field_ff <= field_in;
      last_ff  <= last_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_char_byte     = char_ff;
   assign rsp_doc_id        = doc_ff;
   assign rsp_term_freq     = tf_ff;
   assign rsp_field_code    = field_ff;
   assign rsp_last_posting  = last_ff;
   assign rsp_freq_overflow = ovf_ff;

endmodule

// ===== design/posting_list_nibble_decoder.sv =====
// Posting list nibble decoder, top level. One byte per cycle is accepted when the queue
// has room; a result passes through the queue and the back end's output register to the
// rsp ports. Sustained throughput is one item per cycle when rsp_stall is low, set by the
// single-entry pop of the queue into the back end. Reset is synchronous and active high:
// the block returns to the start of a record and clears its accumulators and queue.
// Uses pldec_pkg, pldec_front, pldec_queue and pldec_back.
module posting_list_nibble_decoder #(
   parameter int unsigned ID_MAX_DIGITS = pldec_pkg::ID_MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [7:0]                    rsp_char_byte,
   output logic [pldec_pkg::ID_W-1:0]    rsp_doc_id,
   output logic [pldec_pkg::FREQ_W-1:0]  rsp_term_freq,
   output logic [4:0]                    rsp_field_code,
   output logic                          rsp_last_posting,
   output logic                          rsp_freq_overflow
);

   // The front classifies each byte by record phase. The phase walk (word, id, frequency,
   // field byte, stop) and the id digit count live there, so the front never waits on the
   // arithmetic. Each byte becomes one queued item, except bytes after a stream stop,
   // which are accepted and dropped.
   logic                accept;
   logic                push;
   pldec_pkg::item_type push_item;
   logic                q_full;
   logic                q_valid;
   logic                q_pop;
   pldec_pkg::item_type q_item;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   pldec_front #(
      .ID_MAX_DIGITS(ID_MAX_DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .push      (push),
      .push_item (push_item)
   );

   // The queue lets the front keep taking bytes while a finished result sits stalled
   // in the back end's output register.
   pldec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_item (q_item)
   );

   // The back end applies the two nibble steps of a posting byte together (two
   // multiply-by-ten shift-add steps) and forms the registered result. Items that
   // yield no result are retired even while the output register is stalled.
   pldec_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_char_byte     (rsp_char_byte),
      .rsp_doc_id        (rsp_doc_id),
      .rsp_term_freq     (rsp_term_freq),
      .rsp_field_code    (rsp_field_code),
      .rsp_last_posting  (rsp_last_posting),
      .rsp_freq_overflow (rsp_freq_overflow)
   );

endmodule
